### design/wavp_pkg.sv
package wavp_pkg;

  localparam int DurFracBitsDefault = 16;
  localparam int FifoDepth = 2;
  localparam int OutDataW = 152;

  localparam logic [31:0] TAG_RIFF = 32'h52494646;
  localparam logic [31:0] TAG_WAVE = 32'h57415645;
  localparam logic [31:0] TAG_FMT  = 32'h666D7420;
  localparam logic [31:0] TAG_DATA = 32'h64617461;

  localparam logic [15:0] FMT_PCM   = 16'd1;
  localparam logic [15:0] FMT_FLOAT = 16'd3;
  localparam logic [31:0] FMT_MIN_SIZE = 32'd16;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_BAD_HEADER  = 3'd1;
  localparam logic [2:0] ST_SHORT_FMT   = 3'd2;
  localparam logic [2:0] ST_UNSUPPORTED = 3'd3;
  localparam logic [2:0] ST_DATA_NO_FMT = 3'd4;
  localparam logic [2:0] ST_NO_DATA     = 3'd5;
  localparam logic [2:0] ST_ZERO_FIELD  = 3'd6;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_CHUNK,
    PH_FMT,
    PH_SKIP,
    PH_DONE
  } phase_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL,
    BK_START1,
    BK_DIV1,
    BK_START2,
    BK_DIV2,
    BK_OUT
  } back_state_t;

  // One parsed file: either an error code or the header fields of a data chunk.
  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] data_size;
    logic [31:0] rate;
    logic [15:0] channels;
    logic [15:0] bits;
    logic        is_float;
  } job_t;

endpackage

### design/wavp_front.sv
module wavp_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              beat_i,
  input  logic [7:0]        byte_i,
  input  logic              last_i,
  output logic              push_o,
  output wavp_pkg::job_t    job_o
);

  wavp_pkg::phase_t phase_r, phase_nxt;
  logic [4:0]  pos_r, pos_nxt;
  logic [32:0] skip_r, skip_nxt;
  logic [31:0] tag_r, tag_nxt;
  logic [31:0] size_r, size_nxt;
  logic [15:0] fmt_r, fmt_nxt;
  logic [15:0] ch_r, ch_nxt;
  logic [31:0] rate_r, rate_nxt;
  logic [15:0] bits_r, bits_nxt;
  logic        seen_r, seen_nxt;
  logic        emit;
  wavp_pkg::job_t job;

  always_comb begin
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    skip_nxt  = skip_r;
    tag_nxt   = tag_r;
    size_nxt  = size_r;
    fmt_nxt   = fmt_r;
    ch_nxt    = ch_r;
    rate_nxt  = rate_r;
    bits_nxt  = bits_r;
    seen_nxt  = seen_r;
    emit      = 1'b0;
    job       = '0;
    case (phase_r)
      wavp_pkg::PH_HEADER: begin
        tag_nxt = {tag_r[23:0], byte_i};
        if (pos_r == 5'd3 && tag_nxt != wavp_pkg::TAG_RIFF) begin
          emit = 1'b1;
          job.status = wavp_pkg::ST_BAD_HEADER;
          phase_nxt = wavp_pkg::PH_DONE;
        end else if (pos_r == 5'd11) begin
          if (tag_nxt != wavp_pkg::TAG_WAVE) begin
            emit = 1'b1;
            job.status = wavp_pkg::ST_BAD_HEADER;
            phase_nxt = wavp_pkg::PH_DONE;
          end else begin
            phase_nxt = wavp_pkg::PH_CHUNK;
            pos_nxt = '0;
          end
        end else begin
          pos_nxt = pos_r + 5'd1;
        end
      end
      wavp_pkg::PH_CHUNK: begin
        if (pos_r < 5'd4) begin
          tag_nxt = {tag_r[23:0], byte_i};
        end else begin
          size_nxt = {byte_i, size_r[31:8]};
        end
        if (pos_r == 5'd7) begin
          pos_nxt = '0;
          if (tag_nxt == wavp_pkg::TAG_FMT) begin
            if (size_nxt < wavp_pkg::FMT_MIN_SIZE) begin
              emit = 1'b1;
              job.status = wavp_pkg::ST_SHORT_FMT;
              phase_nxt = wavp_pkg::PH_DONE;
            end else begin
              skip_nxt = {1'b0, size_nxt - wavp_pkg::FMT_MIN_SIZE} + {32'd0, size_nxt[0]};
              phase_nxt = wavp_pkg::PH_FMT;
            end
          end else if (tag_nxt == wavp_pkg::TAG_DATA) begin
            emit = 1'b1;
            phase_nxt = wavp_pkg::PH_DONE;
            if (!seen_r) begin
              job.status = wavp_pkg::ST_DATA_NO_FMT;
            end else if (rate_r == '0 || ch_r == '0 || bits_r[15:3] == '0) begin
              job.status = wavp_pkg::ST_ZERO_FIELD;
            end else begin
              job.status    = wavp_pkg::ST_OK;
              job.data_size = size_nxt;
              job.rate      = rate_r;
              job.channels  = ch_r;
              job.bits      = bits_r;
              job.is_float  = (fmt_r == wavp_pkg::FMT_FLOAT);
            end
          end else begin
            skip_nxt = {1'b0, size_nxt} + {32'd0, size_nxt[0]};
            phase_nxt = (skip_nxt != '0) ? wavp_pkg::PH_SKIP : wavp_pkg::PH_CHUNK;
          end
        end else begin
          pos_nxt = pos_r + 5'd1;
        end
      end
      wavp_pkg::PH_FMT: begin
        case (pos_r)
          5'd0:  fmt_nxt[7:0]    = byte_i;
          5'd1:  fmt_nxt[15:8]   = byte_i;
          5'd2:  ch_nxt[7:0]     = byte_i;
          5'd3:  ch_nxt[15:8]    = byte_i;
          5'd4:  rate_nxt[7:0]   = byte_i;
          5'd5:  rate_nxt[15:8]  = byte_i;
          5'd6:  rate_nxt[23:16] = byte_i;
          5'd7:  rate_nxt[31:24] = byte_i;
          5'd14: bits_nxt[7:0]   = byte_i;
          5'd15: bits_nxt[15:8]  = byte_i;
          default: ;
        endcase
        if (pos_r == 5'd15) begin
          pos_nxt = '0;
          if (fmt_nxt != wavp_pkg::FMT_PCM && fmt_nxt != wavp_pkg::FMT_FLOAT) begin
            emit = 1'b1;
            job.status = wavp_pkg::ST_UNSUPPORTED;
            phase_nxt = wavp_pkg::PH_DONE;
          end else begin
            seen_nxt = 1'b1;
            phase_nxt = (skip_r != '0) ? wavp_pkg::PH_SKIP : wavp_pkg::PH_CHUNK;
          end
        end else begin
          pos_nxt = pos_r + 5'd1;
        end
      end
      wavp_pkg::PH_SKIP: begin
        if (skip_r != '0) begin
          skip_nxt = skip_r - 33'd1;
        end
        if (skip_nxt == '0) begin
          phase_nxt = wavp_pkg::PH_CHUNK;
          pos_nxt = '0;
        end
      end
      default: ;
    endcase
    if (last_i) begin
      if (!emit && phase_nxt != wavp_pkg::PH_DONE) begin
        emit = 1'b1;
        job = '0;
        if (phase_nxt == wavp_pkg::PH_HEADER) begin
          job.status = wavp_pkg::ST_BAD_HEADER;
        end else if (phase_nxt == wavp_pkg::PH_FMT) begin
          job.status = wavp_pkg::ST_SHORT_FMT;
        end else begin
          job.status = wavp_pkg::ST_NO_DATA;
        end
      end
      phase_nxt = wavp_pkg::PH_HEADER;
      pos_nxt   = '0;
      skip_nxt  = '0;
      tag_nxt   = '0;
      size_nxt  = '0;
      fmt_nxt   = '0;
      ch_nxt    = '0;
      rate_nxt  = '0;
      bits_nxt  = '0;
      seen_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= wavp_pkg::PH_HEADER;
      pos_r   <= '0;
      skip_r  <= '0;
      tag_r   <= '0;
      size_r  <= '0;
      fmt_r   <= '0;
      ch_r    <= '0;
      rate_r  <= '0;
      bits_r  <= '0;
      seen_r  <= 1'b0;
    end else if (beat_i) begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      skip_r  <= skip_nxt;
      tag_r   <= tag_nxt;
      size_r  <= size_nxt;
      fmt_r   <= fmt_nxt;
      ch_r    <= ch_nxt;
      rate_r  <= rate_nxt;
      bits_r  <= bits_nxt;
      seen_r  <= seen_nxt;
    end
  end

  assign push_o = beat_i && emit;
  assign job_o  = job;

endmodule

### design/wavp_fifo.sv
module wavp_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_i,
  input  wavp_pkg::job_t data_i,
  output logic           space_o,
  input  logic           pop_i,
  output logic           avail_o,
  output wavp_pkg::job_t data_o
);

  localparam int AW = $clog2(wavp_pkg::FifoDepth);

  wavp_pkg::job_t mem [wavp_pkg::FifoDepth];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;

  always_ff @(posedge clk) begin
    if (push_i) begin
      mem[wp_r] <= data_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push_i) begin
        wp_r <= wp_r + 1'b1;
      end
      if (pop_i) begin
        rp_r <= rp_r + 1'b1;
      end
      cnt_r <= cnt_r + (AW+1)'(push_i) - (AW+1)'(pop_i);
    end
  end

  assign space_o = (cnt_r != (AW+1)'(wavp_pkg::FifoDepth));
  assign avail_o = (cnt_r != '0);
  assign data_o  = mem[rp_r];

endmodule

### design/wavp_div.sv
module wavp_div #(
  parameter int NW = 48
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start_i,
  input  logic [NW-1:0] dividend_i,
  input  logic [31:0]   divisor_i,
  output logic          done_o,
  output logic [NW-1:0] quo_o
);

  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] quo_r;
  logic [31:0]   rem_r;
  logic [31:0]   div_r;
  logic [CW-1:0] cnt_r;
  logic          done_r;
  logic [32:0]   trial;
  logic          fits;

  assign trial = {rem_r, quo_r[NW-1]};
  assign fits  = (trial >= {1'b0, div_r});

  always_ff @(posedge clk) begin
    if (start_i) begin
      quo_r <= dividend_i;
      rem_r <= '0;
      div_r <= divisor_i;
    end else if (cnt_r != '0) begin
      quo_r <= {quo_r[NW-2:0], fits};
      rem_r <= fits ? 32'(trial - {1'b0, div_r}) : trial[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else if (start_i) begin
      cnt_r  <= CW'(NW);
      done_r <= 1'b0;
    end else begin
      done_r <= (cnt_r == CW'(1));
      if (cnt_r != '0) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

  assign done_o = done_r;
  assign quo_o  = quo_r;

endmodule

### design/wavp_back.sv
module wavp_back #(
  parameter int DURATION_FRAC_BITS = wavp_pkg::DurFracBitsDefault
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          avail_i,
  input  wavp_pkg::job_t                job_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [wavp_pkg::OutDataW-1:0] out_data_o
);

  localparam int NW = 32 + DURATION_FRAC_BITS;

  wavp_pkg::back_state_t state_r, state_nxt;
  wavp_pkg::job_t job_r;
  logic [31:0] align_r;
  logic [31:0] frames_r;
  logic [47:0] dur_r;
  logic        ov_r;
  logic [wavp_pkg::OutDataW-1:0] od_r;
  logic        start;
  logic [NW-1:0] dividend;
  logic [31:0]   divisor;
  logic          div_done;
  logic [NW-1:0] quo;
  logic          load_out;
  logic          is_ok;

  assign is_ok = (job_i.status == wavp_pkg::ST_OK);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      wavp_pkg::BK_IDLE:   if (avail_i) begin
        state_nxt = is_ok ? wavp_pkg::BK_MUL : wavp_pkg::BK_OUT;
      end
      wavp_pkg::BK_MUL:    state_nxt = wavp_pkg::BK_START1;
      wavp_pkg::BK_START1: state_nxt = wavp_pkg::BK_DIV1;
      wavp_pkg::BK_DIV1:   if (div_done) begin
        state_nxt = wavp_pkg::BK_START2;
      end
      wavp_pkg::BK_START2: state_nxt = wavp_pkg::BK_DIV2;
      wavp_pkg::BK_DIV2:   if (div_done) begin
        state_nxt = wavp_pkg::BK_OUT;
      end
      wavp_pkg::BK_OUT:    if (!ov_r || out_ready_i) begin
        state_nxt = wavp_pkg::BK_IDLE;
      end
      default: state_nxt = wavp_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    pop_o    = 1'b0;
    start    = 1'b0;
    load_out = 1'b0;
    dividend = NW'(job_r.data_size);
    divisor  = align_r;
    case (state_r)
      wavp_pkg::BK_IDLE:   pop_o = avail_i;
      wavp_pkg::BK_START1: start = 1'b1;
      wavp_pkg::BK_START2: begin
        start    = 1'b1;
        dividend = NW'(frames_r) << DURATION_FRAC_BITS;
        divisor  = job_r.rate;
      end
      wavp_pkg::BK_OUT:    load_out = !ov_r || out_ready_i;
      default: ;
    endcase
  end

  wavp_div #(.NW(NW)) u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .start_i    (start),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .done_o     (div_done),
    .quo_o      (quo)
  );

  always_ff @(posedge clk) begin
    if (pop_o) begin
      job_r    <= job_i;
      frames_r <= '0;
      dur_r    <= '0;
    end
    if (state_r == wavp_pkg::BK_MUL) begin
      align_r <= {16'd0, job_r.channels} * {19'd0, job_r.bits[15:3]};
    end
    if (state_r == wavp_pkg::BK_DIV1 && div_done) begin
      frames_r <= 32'(quo);
    end
    if (state_r == wavp_pkg::BK_DIV2 && div_done) begin
      dur_r <= 48'(quo);
    end
    if (load_out) begin
      od_r <= {4'd0, dur_r, job_r.is_float, job_r.bits, job_r.channels,
               job_r.rate, frames_r, job_r.status};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= wavp_pkg::BK_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_out) begin
        ov_r <= 1'b1;
      end else if (out_ready_i) begin
        ov_r <= 1'b0;
      end
    end
  end

  assign out_valid_o = ov_r;
  assign out_data_o  = od_r;

endmodule

### design/wav_header_duration_probe_top.sv
// WAV header duration probe.
// The input channel carries a WAV file one byte per beat: in_tdata holds the
// byte and in_tlast marks the final byte of the file. A byte is taken in every
// cycle while the internal result queue has room, so the header parser keeps
// pace with the stream and later bytes after a result are simply dropped.
// Each file yields at most one result beat on the output channel: a status
// code plus, on success, frame count, rate, channel count, sample bits, the
// float flag and the duration in unsigned fixed point seconds.
// The front parser classifies the file and pushes a job into a two-entry
// queue; the back end multiplies out the block alignment and runs two
// divisions on one shared bit-per-cycle divider. An error result passes from
// the queue through the back end's idle and output states into the output
// register; a good result also passes through the multiply and both divisions.
// When the receiver stalls, the result holds in the output register, the
// queue fills, and in_tready drops once the queue is full.
// Reset is synchronous and active low and returns the parser to expect a new
// RIFF header; the end of each file does the same.
module wav_header_duration_probe_top #(
  parameter int DURATION_FRAC_BITS = wavp_pkg::DurFracBitsDefault
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [7:0]                    in_tdata,  // stream_byte
  input  logic                          in_tlast,  // end_of_file
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // From bit 0 up: status[3], frame_count[32], rate_hz[32], channel_count[16],
  // sample_bits[16], is_float[1], duration_seconds_q16[48], zero fill[4].
  output logic [wavp_pkg::OutDataW-1:0] out_tdata
);

  logic           beat;
  logic           push;
  logic           space;
  logic           pop;
  logic           avail;
  wavp_pkg::job_t push_job;
  wavp_pkg::job_t head_job;

  assign in_tready = space;
  assign beat      = in_tvalid && space;

  wavp_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .beat_i (beat),
    .byte_i (in_tdata),
    .last_i (in_tlast),
    .push_o (push),
    .job_o  (push_job)
  );

  wavp_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (push),
    .data_i  (push_job),
    .space_o (space),
    .pop_i   (pop),
    .avail_o (avail),
    .data_o  (head_job)
  );

  wavp_back #(.DURATION_FRAC_BITS(DURATION_FRAC_BITS)) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .avail_i     (avail),
    .job_i       (head_job),
    .pop_o       (pop),
    .out_valid_o (out_tvalid),
    .out_ready_i (out_tready),
    .out_data_o  (out_tdata)
  );

endmodule
